// ===== src/dsbd_pkg.sv =====
package dsbd_pkg;

    // default number of class logits kept per detection
    localparam int CLASS_DEPTH_DEF = 32;

    // field widths
    localparam int COORD_W = 16;
    localparam int LOGIT_W = 16;
    localparam int CLASS_W = 8;
    localparam int CONF_W = 17;
    localparam int PIX_W = 13;
    localparam int MDL_W = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    // fixed point widths of the score path
    localparam int EXPV_W = 25;
    localparam int EXPT_W = 24;
    localparam int SUM_W = 33;
    localparam int DVD_W = 41;
    localparam int DVS_W = 33;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CONF_THR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODEL_W = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODEL_H = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_W = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_H = 3'd4;

    // item kinds on tuser
    localparam logic REQ_BOX = 1'b0;
    localparam logic REQ_LOGIT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_LOADK,
        ST_EXP,
        ST_ACC,
        ST_CDIV,
        ST_CWAIT,
        ST_CONF,
        ST_CHK,
        ST_DROP,
        ST_MUL1,
        ST_MUL2,
        ST_MIN,
        ST_PDIV,
        ST_PWAIT,
        ST_POS,
        ST_WDIV,
        ST_WWAIT,
        ST_EXT,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD,
        OP_LOADK,
        OP_EXP,
        OP_ACC,
        OP_CDIV_GO,
        OP_CONF,
        OP_CLEAR,
        OP_MUL1,
        OP_MUL2,
        OP_MIN,
        OP_PDIV_GO,
        OP_POS,
        OP_WDIV_GO,
        OP_EXT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic emit;
        logic in_ready;
    } ctrl_t;

    typedef struct packed {
        logic exp_last;
        logic idx_last;
        logic div_done;
        logic pass;
        logic axis_last;
        logic out_free;
    } status_t;

    // q0.24 factor exp(-2^b/256) for bit b of the logit gap
    function automatic logic [EXPT_W-1:0] exp_factor(input logic [3:0] b);
        logic [EXPT_W-1:0] f;
        case (b)
            4'd0:    f = 24'd16711808;
            4'd1:    f = 24'd16646655;
            4'd2:    f = 24'd16517109;
            4'd3:    f = 24'd16261035;
            4'd4:    f = 24'd15760736;
            4'd5:    f = 24'd14805841;
            4'd6:    f = 24'd13066109;
            4'd7:    f = 24'd10175896;
            4'd8:    f = 24'd6171993;
            4'd9:    f = 24'd2270549;
            4'd10:   f = 24'd307285;
            4'd11:   f = 24'd5628;
            4'd12:   f = 24'd2;
            default: f = 24'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== src/dsbd_ram.sv =====
module dsbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dsbd_div.sv =====
module dsbd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dsbd_pkg::DVD_W-1:0]  dividend,
    input  logic [dsbd_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [dsbd_pkg::DVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(dsbd_pkg::DVD_W);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [dsbd_pkg::DVD_W-1:0] num_reg, num_next;
    logic [dsbd_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [dsbd_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [dsbd_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [dsbd_pkg::DVS_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        trial = {rem_reg, num_reg[dsbd_pkg::DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[dsbd_pkg::DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = dsbd_pkg::DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[dsbd_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[dsbd_pkg::DVS_W-1:0];
                quo_next = {quo_reg[dsbd_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(dsbd_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = !busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/dsbd_ctrl.sv =====
module dsbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_final,
    input  dsbd_pkg::status_t status,
    output dsbd_pkg::ctrl_t   ctrl
);

    dsbd_pkg::state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsbd_pkg::ST_IDLE:
                if (in_valid && in_final) state_next = dsbd_pkg::ST_RD;
            dsbd_pkg::ST_RD:    state_next = dsbd_pkg::ST_LOADK;
            dsbd_pkg::ST_LOADK: state_next = dsbd_pkg::ST_EXP;
            dsbd_pkg::ST_EXP:
                if (status.exp_last) state_next = dsbd_pkg::ST_ACC;
            dsbd_pkg::ST_ACC:
                state_next = status.idx_last ? dsbd_pkg::ST_CDIV : dsbd_pkg::ST_RD;
            dsbd_pkg::ST_CDIV:  state_next = dsbd_pkg::ST_CWAIT;
            dsbd_pkg::ST_CWAIT:
                if (status.div_done) state_next = dsbd_pkg::ST_CONF;
            dsbd_pkg::ST_CONF:  state_next = dsbd_pkg::ST_CHK;
            dsbd_pkg::ST_CHK:
                state_next = status.pass ? dsbd_pkg::ST_MUL1 : dsbd_pkg::ST_DROP;
            dsbd_pkg::ST_DROP:  state_next = dsbd_pkg::ST_IDLE;
            dsbd_pkg::ST_MUL1:  state_next = dsbd_pkg::ST_MUL2;
            dsbd_pkg::ST_MUL2:  state_next = dsbd_pkg::ST_MIN;
            dsbd_pkg::ST_MIN:   state_next = dsbd_pkg::ST_PDIV;
            dsbd_pkg::ST_PDIV:  state_next = dsbd_pkg::ST_PWAIT;
            dsbd_pkg::ST_PWAIT:
                if (status.div_done) state_next = dsbd_pkg::ST_POS;
            dsbd_pkg::ST_POS:   state_next = dsbd_pkg::ST_WDIV;
            dsbd_pkg::ST_WDIV:  state_next = dsbd_pkg::ST_WWAIT;
            dsbd_pkg::ST_WWAIT:
                if (status.div_done) state_next = dsbd_pkg::ST_EXT;
            dsbd_pkg::ST_EXT:
                state_next = status.axis_last ? dsbd_pkg::ST_EMIT : dsbd_pkg::ST_MUL1;
            dsbd_pkg::ST_EMIT:
                if (status.out_free) state_next = dsbd_pkg::ST_IDLE;
            default:            state_next = dsbd_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        ctrl.op = dsbd_pkg::OP_NONE;
        ctrl.emit = 1'b0;
        ctrl.in_ready = 1'b0;
        case (state_reg)
            dsbd_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid) ctrl.op = dsbd_pkg::OP_ACCEPT;
            end
            dsbd_pkg::ST_RD:    ctrl.op = dsbd_pkg::OP_RD;
            dsbd_pkg::ST_LOADK: ctrl.op = dsbd_pkg::OP_LOADK;
            dsbd_pkg::ST_EXP:   ctrl.op = dsbd_pkg::OP_EXP;
            dsbd_pkg::ST_ACC:   ctrl.op = dsbd_pkg::OP_ACC;
            dsbd_pkg::ST_CDIV:  ctrl.op = dsbd_pkg::OP_CDIV_GO;
            dsbd_pkg::ST_CONF:  ctrl.op = dsbd_pkg::OP_CONF;
            dsbd_pkg::ST_DROP:  ctrl.op = dsbd_pkg::OP_CLEAR;
            dsbd_pkg::ST_MUL1:  ctrl.op = dsbd_pkg::OP_MUL1;
            dsbd_pkg::ST_MUL2:  ctrl.op = dsbd_pkg::OP_MUL2;
            dsbd_pkg::ST_MIN:   ctrl.op = dsbd_pkg::OP_MIN;
            dsbd_pkg::ST_PDIV:  ctrl.op = dsbd_pkg::OP_PDIV_GO;
            dsbd_pkg::ST_POS:   ctrl.op = dsbd_pkg::OP_POS;
            dsbd_pkg::ST_WDIV:  ctrl.op = dsbd_pkg::OP_WDIV_GO;
            dsbd_pkg::ST_EXT:   ctrl.op = dsbd_pkg::OP_EXT;
            dsbd_pkg::ST_EMIT:
                if (status.out_free)
                begin
                    ctrl.op = dsbd_pkg::OP_CLEAR;
                    ctrl.emit = 1'b1;
                end
            default:            ctrl.op = dsbd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/dsbd_dp.sv =====
module dsbd_dp #(
    parameter int CLASS_DEPTH = dsbd_pkg::CLASS_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dsbd_pkg::ctrl_t                     ctrl,
    output dsbd_pkg::status_t                   status,
    input  logic                                in_type,
    input  logic [dsbd_pkg::COORD_W-1:0]        in_cx,
    input  logic [dsbd_pkg::COORD_W-1:0]        in_cy,
    input  logic [dsbd_pkg::COORD_W-1:0]        in_bw,
    input  logic [dsbd_pkg::COORD_W-1:0]        in_bh,
    input  logic signed [dsbd_pkg::LOGIT_W-1:0] in_logit,
    input  logic                                cfg_we,
    input  logic [dsbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dsbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [dsbd_pkg::CLASS_W-1:0]        out_class,
    output logic [dsbd_pkg::CONF_W-1:0]         out_conf,
    output logic [dsbd_pkg::PIX_W-1:0]          out_left,
    output logic [dsbd_pkg::PIX_W-1:0]          out_top,
    output logic [dsbd_pkg::PIX_W-1:0]          out_width,
    output logic [dsbd_pkg::PIX_W-1:0]          out_height
);

    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam int AW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam logic [dsbd_pkg::CONF_W-1:0] CONF_ONE = 17'd65536;
    localparam logic [dsbd_pkg::PIX_W-1:0] PIX_MAX = 13'd8191;

    // configuration
    logic [dsbd_pkg::CONF_W-1:0] thr_reg;
    logic [dsbd_pkg::MDL_W-1:0]  mw_reg, mh_reg;
    logic [dsbd_pkg::PIX_W-1:0]  fw_reg, fh_reg;

    // detection state
    logic [dsbd_pkg::COORD_W-1:0]        cx_reg, cy_reg, bw_reg, bh_reg;
    logic [CW-1:0]                       count_reg, idx_reg;
    logic signed [dsbd_pkg::LOGIT_W-1:0] best_reg;
    logic [dsbd_pkg::CLASS_W-1:0]        bidx_reg;

    // score path
    logic [dsbd_pkg::LOGIT_W-1:0] k_reg;
    logic [dsbd_pkg::EXPV_W-1:0]  v_reg;
    logic [3:0]                   bit_reg;
    logic [dsbd_pkg::SUM_W-1:0]   sum_reg;
    logic [dsbd_pkg::CONF_W-1:0]  conf_reg;

    // box path
    logic                   axis_reg;
    logic [30:0]            xpos_reg;
    logic [29:0]            ws_reg;
    logic [16:0]            d_reg;
    logic [29:0]            fd_reg;
    logic signed [31:0]     w_reg;
    logic [dsbd_pkg::PIX_W-1:0] left_reg, top_reg, wd_reg, ht_reg;

    // result register
    logic                         ov_reg;
    logic [dsbd_pkg::CLASS_W-1:0] oc_reg;
    logic [dsbd_pkg::CONF_W-1:0]  of_reg;
    logic [dsbd_pkg::PIX_W-1:0]   ol_reg, ot_reg, ow_reg, oh_reg;

    logic                          accept, store_we;
    logic [dsbd_pkg::LOGIT_W-1:0]  rdata;
    logic signed [dsbd_pkg::LOGIT_W:0] gap;
    logic [48:0]                   prod;
    logic [dsbd_pkg::EXPV_W-1:0]   v_step;
    logic                          div_start, div_done;
    logic [dsbd_pkg::DVD_W-1:0]    dvd, quo;
    logic [dsbd_pkg::DVS_W-1:0]    dvs;
    logic [dsbd_pkg::COORD_W-1:0]  ctr, sz;
    logic [dsbd_pkg::MDL_W-1:0]    mdl;
    logic [dsbd_pkg::PIX_W-1:0]    frm;
    logic signed [17:0]            span;
    logic signed [31:0]            xprod;
    logic signed [31:0]            lim;
    logic [dsbd_pkg::PIX_W-1:0]    q_sat;

    assign accept = (ctrl.op == dsbd_pkg::OP_ACCEPT);
    assign store_we = accept && (in_type == dsbd_pkg::REQ_LOGIT)
                      && (count_reg < CW'(CLASS_DEPTH));

    dsbd_ram #(
        .WIDTH (dsbd_pkg::LOGIT_W),
        .DEPTH (CLASS_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_logit),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // gap to the best logit and one exp factor step
    assign gap = $signed({best_reg[dsbd_pkg::LOGIT_W-1], best_reg})
                 - $signed({rdata[dsbd_pkg::LOGIT_W-1], rdata});
    assign prod = 49'(v_reg) * 49'(dsbd_pkg::exp_factor(bit_reg));
    assign v_step = dsbd_pkg::EXPV_W'((prod + 49'd8388608) >> 24);

    // axis operand select
    assign ctr = axis_reg ? cy_reg : cx_reg;
    assign sz = axis_reg ? bh_reg : bw_reg;
    assign mdl = axis_reg ? mh_reg : mw_reg;
    assign frm = axis_reg ? fh_reg : fw_reg;
    assign span = $signed({1'b0, ctr, 1'b0}) - $signed({2'b00, sz});
    assign xprod = 32'($signed({1'b0, frm})) * 32'(span);
    assign lim = $signed({2'b00, fd_reg}) - $signed({1'b0, xpos_reg});
    assign q_sat = (quo > dsbd_pkg::DVD_W'(PIX_MAX)) ? PIX_MAX : quo[dsbd_pkg::PIX_W-1:0];

    // shared divider operands
    always_comb
    begin
        div_start = 1'b0;
        dvd = '0;
        dvs = dsbd_pkg::DVS_W'(d_reg);
        case (ctrl.op)
            dsbd_pkg::OP_CDIV_GO:
            begin
                div_start = 1'b1;
                dvd = {1'b1, {(dsbd_pkg::DVD_W-1){1'b0}}};
                dvs = sum_reg;
            end
            dsbd_pkg::OP_PDIV_GO:
            begin
                div_start = 1'b1;
                dvd = dsbd_pkg::DVD_W'(xpos_reg);
            end
            dsbd_pkg::OP_WDIV_GO:
            begin
                div_start = 1'b1;
                dvd = w_reg[31] ? '0 : dsbd_pkg::DVD_W'(w_reg[30:0]);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    dsbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 17'd16384;
            mw_reg <= 12'd640;
            mh_reg <= 12'd640;
            fw_reg <= 13'd640;
            fh_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dsbd_pkg::CFG_CONF_THR: thr_reg <= cfg_data;
                dsbd_pkg::CFG_MODEL_W:  mw_reg <= cfg_data[dsbd_pkg::MDL_W-1:0];
                dsbd_pkg::CFG_MODEL_H:  mh_reg <= cfg_data[dsbd_pkg::MDL_W-1:0];
                dsbd_pkg::CFG_FRAME_W:  fw_reg <= cfg_data[dsbd_pkg::PIX_W-1:0];
                dsbd_pkg::CFG_FRAME_H:  fh_reg <= cfg_data[dsbd_pkg::PIX_W-1:0];
                default:                thr_reg <= thr_reg;
            endcase
        end
    end

    // detection tracking: held box, count, running best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            bw_reg <= '0;
            bh_reg <= '0;
            count_reg <= '0;
            best_reg <= {1'b1, {(dsbd_pkg::LOGIT_W-1){1'b0}}};
            bidx_reg <= '0;
        end
        else if (accept && (in_type == dsbd_pkg::REQ_BOX))
        begin
            cx_reg <= in_cx;
            cy_reg <= in_cy;
            bw_reg <= in_bw;
            bh_reg <= in_bh;
            count_reg <= '0;
            best_reg <= {1'b1, {(dsbd_pkg::LOGIT_W-1){1'b0}}};
            bidx_reg <= '0;
        end
        else if (store_we)
        begin
            if ((count_reg == '0) || (in_logit > best_reg))
            begin
                best_reg <= in_logit;
                bidx_reg <= dsbd_pkg::CLASS_W'(count_reg);
            end
            count_reg <= CW'(count_reg + 1'b1);
        end
        else if (ctrl.op == dsbd_pkg::OP_CLEAR)
        begin
            count_reg <= '0;
            best_reg <= {1'b1, {(dsbd_pkg::LOGIT_W-1){1'b0}}};
            bidx_reg <= '0;
        end
    end

    // sum pass over the stored logits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            bit_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            case (ctrl.op)
                dsbd_pkg::OP_ACCEPT:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                end
                dsbd_pkg::OP_LOADK:
                begin
                    bit_reg <= '0;
                end
                dsbd_pkg::OP_EXP:
                begin
                    bit_reg <= bit_reg + 4'd1;
                end
                dsbd_pkg::OP_ACC:
                begin
                    sum_reg <= sum_reg + dsbd_pkg::SUM_W'(v_reg);
                    idx_reg <= CW'(idx_reg + 1'b1);
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // score and box datapath registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            dsbd_pkg::OP_LOADK:
            begin
                k_reg <= gap[dsbd_pkg::LOGIT_W-1:0];
                v_reg <= dsbd_pkg::EXPV_W'(1) << 24;
            end
            dsbd_pkg::OP_EXP:
            begin
                if (k_reg[bit_reg]) v_reg <= v_step;
            end
            dsbd_pkg::OP_CONF:
            begin
                conf_reg <= (quo > dsbd_pkg::DVD_W'(CONF_ONE)) ? CONF_ONE
                            : quo[dsbd_pkg::CONF_W-1:0];
            end
            dsbd_pkg::OP_MUL1:
            begin
                xpos_reg <= xprod[31] ? '0 : xprod[30:0];
                ws_reg <= {(29'(frm) * 29'(sz)), 1'b0};
                d_reg <= {((mdl == '0) ? dsbd_pkg::MDL_W'(1) : mdl), 5'b00000};
            end
            dsbd_pkg::OP_MUL2:
            begin
                fd_reg <= 30'(frm) * 30'(d_reg);
            end
            dsbd_pkg::OP_MIN:
            begin
                w_reg <= (lim < $signed({2'b00, ws_reg})) ? lim : $signed({2'b00, ws_reg});
            end
            dsbd_pkg::OP_POS:
            begin
                if (axis_reg) top_reg <= q_sat;
                else left_reg <= q_sat;
            end
            dsbd_pkg::OP_EXT:
            begin
                if (axis_reg) ht_reg <= q_sat;
                else wd_reg <= q_sat;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // axis select: x first, then y
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 1'b0;
        end
        else if (ctrl.op == dsbd_pkg::OP_EXT)
        begin
            axis_reg <= !axis_reg;
        end
    end

    // result register toward the master side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            oc_reg <= bidx_reg;
            of_reg <= conf_reg;
            ol_reg <= left_reg;
            ot_reg <= top_reg;
            ow_reg <= wd_reg;
            oh_reg <= ht_reg;
        end
    end

    assign status.exp_last = (bit_reg == 4'd15);
    assign status.idx_last = (CW'(idx_reg + 1'b1) >= count_reg);
    assign status.div_done = div_done;
    assign status.pass = (conf_reg >= thr_reg);
    assign status.axis_last = axis_reg;
    assign status.out_free = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_class = oc_reg;
    assign out_conf = of_reg;
    assign out_left = ol_reg;
    assign out_top = ot_reg;
    assign out_width = ow_reg;
    assign out_height = oh_reg;

endmodule

// ===== src/detection_score_and_box_decode.sv =====
// Detection post-processing: one box beat (tuser 0) opens a detection, then one class
// logit per beat (tuser 1), the final one marked by tlast. Box and logit beats are taken
// back to back while the block is idle. On the final logit a sum pass walks the m stored
// logits, each a logit memory read plus a 16-step exp product on one 25x24 multiplier; the
// confidence and the four box divisions then run on one shared restoring divider, each
// division a start, 41 quotient bits and done. After the sum pass a result below the
// confidence threshold is dropped, otherwise it is emitted once the output is free. A
// result beat waits in its own output register.
module detection_score_and_box_decode #(
    parameter int CLASS_DEPTH = dsbd_pkg::CLASS_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // center_x[15:0], center_y[31:16], box_w[47:32], box_h[63:48], logit[79:64]
    input  logic [79:0]                         s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // class_id[7:0], confidence[24:8], left[37:25], top[50:38], width[63:51],
    // height[76:64], zero fill [79:77]
    output logic [79:0]                         m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [dsbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dsbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dsbd_pkg::ctrl_t   ctrl;
    dsbd_pkg::status_t status;

    logic [dsbd_pkg::CLASS_W-1:0] out_class;
    logic [dsbd_pkg::CONF_W-1:0]  out_conf;
    logic [dsbd_pkg::PIX_W-1:0]   out_left, out_top, out_width, out_height;

    dsbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_final (s_axis_tuser && s_axis_tlast),
        .status   (status),
        .ctrl     (ctrl)
    );

    dsbd_dp #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .in_type    (s_axis_tuser),
        .in_cx      (s_axis_tdata[15:0]),
        .in_cy      (s_axis_tdata[31:16]),
        .in_bw      (s_axis_tdata[47:32]),
        .in_bh      (s_axis_tdata[63:48]),
        .in_logit   (s_axis_tdata[79:64]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_class  (out_class),
        .out_conf   (out_conf),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_width  (out_width),
        .out_height (out_height)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tdata = {3'b000, out_height, out_width, out_top, out_left,
                           out_conf, out_class};

endmodule

// ===== dv/detection_score_and_box_decode_test.sv =====
module detection_score_and_box_decode_test;

    localparam int N_CLASSES = dsbd_pkg::CLASS_DEPTH_DEF;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [79:0] data;
        logic        kind;
        logic        last;
    } beat_t;

    typedef struct {
        logic [dsbd_pkg::CLASS_W-1:0] class_id;
        logic [dsbd_pkg::CONF_W-1:0]  conf;
        logic [dsbd_pkg::PIX_W-1:0]   left;
        logic [dsbd_pkg::PIX_W-1:0]   top;
        logic [dsbd_pkg::PIX_W-1:0]   width;
        logic [dsbd_pkg::PIX_W-1:0]   height;
    } detection_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [79:0]                     s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [79:0]                     m_axis_tdata;
    logic                            cfg_we;
    logic [dsbd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [dsbd_pkg::CFG_DATA_W-1:0] cfg_data;

    detection_score_and_box_decode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // pending input beats, expected detections
    beat_t      beat_q[$];
    detection_t detect_q[$];
    beat_t      drv_beat;
    idle_mode_t idle_mode;

    int errors = 0;
    int beats_sent = 0;
    int detections_seen = 0;
    int quiet_cycles = 0;

    // predictor registers and detection state
    logic [dsbd_pkg::CONF_W-1:0] thr_r;
    logic [dsbd_pkg::MDL_W-1:0]  mdl_w_r;
    logic [dsbd_pkg::MDL_W-1:0]  mdl_h_r;
    logic [dsbd_pkg::PIX_W-1:0]  frm_w_r;
    logic [dsbd_pkg::PIX_W-1:0]  frm_h_r;
    logic signed [15:0]          logits[N_CLASSES];
    int                          n_logits = 0;
    logic signed [15:0]          top_logit = 16'sh8000;
    int                          top_index = 0;
    logic [63:0]                 box_r = '0;

    // exp(-gap/256) in q0.24 as a product of per-bit factors
    function automatic longint exp_of_gap(logic [15:0] gap);
        longint v;
        v = longint'(1) << 24;
        for (int b = 0; b < 16; b++)
            if (gap[b])
                v = (v * longint'(dsbd_pkg::exp_factor(b[3:0])) + (longint'(1) << 23)) >> 24;
        return v;
    endfunction

    // one axis of the model to frame mapping
    function automatic void map_axis(input longint ctr, input longint sz, input longint mdl,
                                     input longint frm, output logic [dsbd_pkg::PIX_W-1:0] pos,
                                     output logic [dsbd_pkg::PIX_W-1:0] ext);
        longint d;
        longint x;
        longint w;
        longint p;
        longint e;
        d = 32 * ((mdl == 0) ? 1 : mdl);
        x = frm * (2 * ctr - sz);
        if (x < 0)
            x = 0;
        w = 2 * frm * sz;
        if (frm * d - x < w)
            w = frm * d - x;
        p = x / d;
        pos = (p > 8191) ? 13'd8191 : p[dsbd_pkg::PIX_W-1:0];
        e = (w < 0) ? 0 : w / d;
        ext = (e > 8191) ? 13'd8191 : e[dsbd_pkg::PIX_W-1:0];
    endfunction

    function automatic void clear_scores();
        n_logits = 0;
        top_logit = 16'sh8000;
        top_index = 0;
    endfunction

    // predictor step for one accepted beat
    task automatic decode_beat(beat_t bt);
        logic signed [15:0] lg;
        longint             sum;
        longint             conf;
        detection_t         det;
        if (bt.kind == dsbd_pkg::REQ_BOX)
        begin
            box_r = bt.data[63:0];
            clear_scores();
            return;
        end
        lg = bt.data[79:64];
        if (n_logits < N_CLASSES)
        begin
            logits[n_logits] = lg;
            if (n_logits == 0 || lg > top_logit)
            begin
                top_logit = lg;
                top_index = n_logits;
            end
            n_logits++;
        end
        if (!bt.last)
            return;
        sum = 0;
        for (int i = 0; i < n_logits; i++)
            sum += exp_of_gap(16'(top_logit - logits[i]));
        conf = (sum == 0) ? 65536 : (longint'(1) << 40) / sum;
        if (conf > 65536)
            conf = 65536;
        det.class_id = top_index[dsbd_pkg::CLASS_W-1:0];
        clear_scores();
        if (conf < longint'(thr_r))
            return;
        det.conf = conf[dsbd_pkg::CONF_W-1:0];
        map_axis(box_r[15:0], box_r[47:32], mdl_w_r, frm_w_r, det.left, det.width);
        map_axis(box_r[31:16], box_r[63:48], mdl_h_r, frm_h_r, det.top, det.height);
        detect_q.insert(detect_q.size(), det);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // stimulus builders
    task automatic push_box(logic [15:0] cx, logic [15:0] cy, logic [15:0] bw,
                            logic [15:0] bh, logic last);
        beat_t bt;
        bt.data = {16'($urandom), bh, bw, cy, cx};
        bt.kind = dsbd_pkg::REQ_BOX;
        bt.last = last;
        beat_q.insert(beat_q.size(), bt);
    endtask

    task automatic push_logit(logic [15:0] lg, logic last);
        beat_t bt;
        bt.data = {lg, 32'($urandom), 32'($urandom)};
        bt.kind = dsbd_pkg::REQ_LOGIT;
        bt.last = last;
        beat_q.insert(beat_q.size(), bt);
    endtask

    task automatic push_detection();
        int          n;
        int          pick;
        int          spread;
        logic [15:0] base;
        pick = $urandom_range(99);
        // mostly a box first, sometimes logits reuse the held box
        if ($urandom_range(99) < 85)
        begin
            if ($urandom_range(1))
                push_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
            else
                push_box(16'($urandom_range(10239)), 16'($urandom_range(10239)),
                         16'($urandom_range(6000)), 16'($urandom_range(6000)),
                         1'($urandom));
        end
        if (pick < 70)
            n = $urandom_range(1, 6);
        else if (pick < 95)
            n = $urandom_range(7, 31);
        else
            n = $urandom_range(32, 35);
        base = 16'($urandom);
        spread = ($urandom_range(9) == 0) ? 65535 : (1 << $urandom_range(4, 11));
        for (int i = 0; i < n; i++)
        begin
            if (spread == 65535)
                push_logit(16'($urandom), i == n - 1);
            else
                push_logit(base + 16'($urandom_range(spread)) - 16'(spread / 2), i == n - 1);
        end
    endtask

    task automatic write_reg(logic [dsbd_pkg::CFG_ADDR_W-1:0] addr,
                             logic [dsbd_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
    endtask

    task automatic write_all(int thr, int mw, int mh, int fw, int fh);
        write_reg(dsbd_pkg::CFG_CONF_THR, dsbd_pkg::CFG_DATA_W'(thr));
        write_reg(dsbd_pkg::CFG_MODEL_W, dsbd_pkg::CFG_DATA_W'(mw));
        write_reg(dsbd_pkg::CFG_MODEL_H, dsbd_pkg::CFG_DATA_W'(mh));
        write_reg(dsbd_pkg::CFG_FRAME_W, dsbd_pkg::CFG_DATA_W'(fw));
        write_reg(dsbd_pkg::CFG_FRAME_H, dsbd_pkg::CFG_DATA_W'(fh));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // let queued beats drain and the block go quiet
    task automatic drain();
        wait (beat_q.size() == 0 && !s_axis_tvalid && detect_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int target;
        target = beat_q.size() + count;
        while (beat_q.size() < target)
            push_detection();
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // predictor register copies follow the write port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_r <= 17'd16384;
            mdl_w_r <= 12'd640;
            mdl_h_r <= 12'd640;
            frm_w_r <= 13'd640;
            frm_h_r <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dsbd_pkg::CFG_CONF_THR: thr_r <= cfg_data;
                dsbd_pkg::CFG_MODEL_W:  mdl_w_r <= cfg_data[dsbd_pkg::MDL_W-1:0];
                dsbd_pkg::CFG_MODEL_H:  mdl_h_r <= cfg_data[dsbd_pkg::MDL_W-1:0];
                dsbd_pkg::CFG_FRAME_W:  frm_w_r <= cfg_data[dsbd_pkg::PIX_W-1:0];
                dsbd_pkg::CFG_FRAME_H:  frm_h_r <= cfg_data[dsbd_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // input driver
    always @(posedge clk)
    begin : drive_proc
        logic hold_off;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_beat(drv_beat);
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                hold_off = (idle_mode == IDLE_SEND && $urandom_range(99) < 64) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 15);
                if (beat_q.size() > 0 && !hold_off)
                begin
                    drv_beat = beat_q.pop_front();
                    s_axis_tdata <= drv_beat.data;
                    s_axis_tuser <= drv_beat.kind;
                    s_axis_tlast <= drv_beat.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : monitor_proc
        detection_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                detections_seen++;
                if (detect_q.size() == 0)
                begin
                    report("unexpected result beat, class_id", m_axis_tdata[7:0], -1);
                end
                else
                begin
                    want = detect_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.class_id)
                        report("class_id", m_axis_tdata[7:0], want.class_id);
                    if (m_axis_tdata[24:8] !== want.conf)
                        report("confidence", m_axis_tdata[24:8], want.conf);
                    if (m_axis_tdata[37:25] !== want.left)
                        report("left", m_axis_tdata[37:25], want.left);
                    if (m_axis_tdata[50:38] !== want.top)
                        report("top", m_axis_tdata[50:38], want.top);
                    if (m_axis_tdata[63:51] !== want.width)
                        report("width", m_axis_tdata[63:51], want.width);
                    if (m_axis_tdata[76:64] !== want.height)
                        report("height", m_axis_tdata[76:64], want.height);
                end
            end
            if (idle_mode == IDLE_RECV)
                m_axis_tready <= ($urandom_range(99) >= 64);
            else if (idle_mode == IDLE_BOTH)
                m_axis_tready <= ($urandom_range(99) >= 15);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("detection_score_and_box_decode: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        idle_mode = IDLE_NONE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: logit before any box uses the zero box
        push_logit(16'h7fff, 1'b1);
        // extreme box, extreme logits
        push_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        push_logit(16'h8000, 1'b0);
        push_logit(16'h7fff, 1'b1);
        // marked box beat is ignored, ties keep the first index
        push_box(16'd5120, 16'd5120, 16'd1600, 16'd1600, 1'b1);
        push_logit(16'd100, 1'b0);
        push_logit(16'd100, 1'b0);
        push_logit(16'd100, 1'b1);
        // low confidence is dropped
        push_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            push_logit(16'd0, i == 7);
        // logits reuse the held box
        push_logit(16'h8000, 1'b0);
        push_logit(16'h0200, 1'b1);
        run_random(200);
        drain();

        // extreme registers, left saturating beyond the frame
        write_all(0, 1, 4095, 8191, 1);
        idle_mode = IDLE_SEND;
        push_box(16'hffff, 16'hffff, 16'd0, 16'hffff, 1'b0);
        push_logit(16'h1234, 1'b1);
        run_random(220);
        drain();

        // zero model size and a full threshold
        write_all(65536, 0, 0, 8191, 8191);
        idle_mode = IDLE_RECV;
        run_random(200);
        drain();

        // random mid-range setting
        write_all($urandom_range(40000), $urandom_range(1, 4095), $urandom_range(1, 4095),
                  $urandom_range(1, 8191), $urandom_range(1, 8191));
        idle_mode = IDLE_BOTH;
        run_random(200);
        drain();

        // threshold past one, nothing emitted
        write_all(131071, 4095, 1, 1, 8191);
        idle_mode = IDLE_NONE;
        run_random(60);
        drain();

        write_all(20000, 640, 640, 1920, 1080);
        idle_mode = IDLE_BOTH;
        run_random(220);
        drain();

        $display("%0d input beats over six register settings, %0d detections checked",
                 beats_sent, detections_seen);
        $display("idle modes: none, sender gaps, receiver stalls, both");
        if (errors == 0 && detect_q.size() == 0)
            $display("detection_score_and_box_decode: match");
        else
            $display("detection_score_and_box_decode: mismatch");
        $finish;
    end

endmodule

// ===== detection_score_and_box_decode.f =====
src/dsbd_pkg.sv
src/dsbd_ram.sv
src/dsbd_div.sv
src/dsbd_ctrl.sv
src/dsbd_dp.sv
src/detection_score_and_box_decode.sv
dv/detection_score_and_box_decode_test.sv
